>>> hdl/srdz_pkg.sv
// ---------------------------------------------------------------------------
// srdz_pkg: shared types and constants for the scaled radial dead zone.
// Holds the sample format, the widths of the pipelined arithmetic and the
// record that travels down the chain of cells.
// ---------------------------------------------------------------------------
package srdz_pkg;

    localparam int SampleBits = 16;
    localparam int FracBits   = SampleBits - 1;
    localparam int MagBits    = SampleBits;          // |x|, |y| up to 2^F
    localparam int SqBits     = 2 * MagBits + 1;     // x*x + y*y
    localparam int RootBits   = MagBits + 1;         // floor(sqrt(sq))
    localparam int NumBits    = MagBits + FracBits;  // dividend of the divides
    localparam int QuoBits    = NumBits + 1;
    localparam int DzBits     = 15;

    // Square root cells: one result bit per cell.
    localparam int SqrtCells = RootBits;
    // Divide cells: one quotient bit per cell, one per dividend bit.
    localparam int DivCells  = NumBits;

    localparam logic [MagBits-1:0] OneQ = MagBits'(1) << FracBits;

    typedef logic [SampleBits-1:0] sample_t;

    // Record carried by the input cell and every square root cell of the chain.
    typedef struct packed {
        logic                neg_x;
        logic                neg_y;
        logic [MagBits-1:0]  ax;
        logic [MagBits-1:0]  ay;
        logic [DzBits-1:0]   dz;
        logic                dead;
        logic [SqBits-1:0]   rem;    // square root remainder
        logic [RootBits-1:0] root;   // square root partial result
    } srdz_sq_t;

    // One long division lane: numerator shifted in, remainder, quotient.
    typedef struct packed {
        logic [NumBits-1:0]  num;
        logic [RootBits:0]   rem;
        logic [QuoBits-1:0]  quo;
    } srdz_div_t;

    typedef struct packed {
        logic                neg_x;
        logic                neg_y;
        logic                dead;
        logic                zero;
        logic [RootBits-1:0] den_m;  // magnitude, divisor of both directions
        logic [RootBits-1:0] den_k;  // 2^F - d, divisor of the factor
        srdz_div_t           dx;
        srdz_div_t           dy;
        srdz_div_t           dk;
    } srdz_dv_t;

endpackage

>>> hdl/srdz_sqrt_cell.sv
// ---------------------------------------------------------------------------
// srdz_sqrt_cell: one restoring square root step.
// Decides one result bit and hands the record to the next cell.
// ---------------------------------------------------------------------------
module srdz_sqrt_cell (
    input  logic                aclk,
    input  logic                en,
    input  logic [4:0]          bit_pos,
    input  srdz_pkg::srdz_sq_t  in_rec,
    output srdz_pkg::srdz_sq_t  out_rec
);
    import srdz_pkg::*;

    logic [SqBits+1:0] trial;
    srdz_sq_t          nxt;

    // Trial value (4*root + 1) << 2*bit_pos, root kept as the high bits.
    always_comb begin
        nxt   = in_rec;
        trial = (((SqBits+2)'(in_rec.root) << 2) | (SqBits+2)'(1)) << (2 * bit_pos);
        if ((SqBits+2)'(in_rec.rem) >= trial) begin
            nxt.rem  = SqBits'((SqBits+2)'(in_rec.rem) - trial);
            nxt.root = (in_rec.root << 1) | RootBits'(1);
        end else begin
            nxt.root = in_rec.root << 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_rec <= nxt;
        end
    end
endmodule

>>> hdl/srdz_div_cell.sv
// ---------------------------------------------------------------------------
// srdz_div_cell: one restoring division step for three lanes.
// Shifts one numerator bit into each remainder and decides a quotient bit.
// ---------------------------------------------------------------------------
module srdz_div_cell (
    input  logic               aclk,
    input  logic               en,
    input  srdz_pkg::srdz_dv_t in_rec,
    output srdz_pkg::srdz_dv_t out_rec
);
    import srdz_pkg::*;

    srdz_dv_t nxt;

    function automatic srdz_div_t step(srdz_div_t l, logic [RootBits-1:0] den);
        logic [RootBits+1:0] r;
        srdz_div_t           o;
        r     = {l.rem, l.num[NumBits-1]};
        o     = l;
        o.num = l.num << 1;
        if (r >= (RootBits+2)'(den)) begin
            o.rem = (RootBits+1)'(r - (RootBits+2)'(den));
            o.quo = {l.quo[QuoBits-2:0], 1'b1};
        end else begin
            o.rem = (RootBits+1)'(r);
            o.quo = {l.quo[QuoBits-2:0], 1'b0};
        end
        return o;
    endfunction

    always_comb begin
        nxt    = in_rec;
        nxt.dx = step(in_rec.dx, in_rec.den_m);
        nxt.dy = step(in_rec.dy, in_rec.den_m);
        nxt.dk = step(in_rec.dk, in_rec.den_k);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_rec <= nxt;
        end
    end
endmodule

>>> hdl/scaled_radial_dead_zone.sv
// ---------------------------------------------------------------------------
// scaled_radial_dead_zone: radial dead zone with rescaled stick output.
// Computes the stick magnitude, the unit direction and the direction scaled
// by (m - d) / (1 - d), all in saturated Q1.15.
// ---------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake               | Contents
//  ---------+-----------+-------------------------+--------------------------
//  s_axis   | in        | s_tvalid / s_tready     | axis_x, axis_y
//  m_axis   | out       | m_tvalid / m_tready     | scaled/dir x,y; dead flag
//  cfg      | in        | cfg_valid / cfg_ready   | dead_zone_radius
//
// One transaction is accepted every cycle while the chain is not stalled. The
// chain holds one input cell, 17 square root cells, a setup cell, 31 divide
// cells, a multiply cell and a saturation cell. The whole chain advances
// together and stalls only when the output register holds a transaction that
// is not taken; a new transaction may still enter while the last cell is empty.
// Reset (aresetn, synchronous) clears only valid bits, sets the radius to 0.25.
// ---------------------------------------------------------------------------
module scaled_radial_dead_zone (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] axis_x, [31:16] axis_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // scaled_x, scaled_y, dir_x, dir_y
    output logic        m_tuser,   // in_dead_zone
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data
);
    import srdz_pkg::*;

    localparam int Stages   = 1 + SqrtCells + 1 + DivCells + 2;
    localparam int ProdBits = MagBits + QuoBits;

    logic [DzBits-1:0] dz_reg;
    logic [Stages-1:0] vld_reg;
    logic              adv;

    // The chain moves when its last stage is empty or is being drained.
    assign adv       = !vld_reg[Stages-1] || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[Stages-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dz_reg  <= DzBits'(8192);
            vld_reg <= '0;
        end else begin
            if (cfg_valid) begin
                dz_reg <= cfg_data;
            end
            if (adv) begin
                vld_reg <= {vld_reg[Stages-2:0], s_tvalid};
            end
        end
    end

    // Input cell: magnitudes, signs, squared magnitude and dead-zone test.
    sample_t             ix, iy;
    logic [MagBits-1:0]  iax, iay;
    logic [SqBits-1:0]   isq;
    srdz_sq_t            in_rec;
    srdz_sq_t            sq_chain [SqrtCells+1];

    assign ix  = s_tdata[15:0];
    assign iy  = s_tdata[31:16];
    assign iax = ix[SampleBits-1] ? MagBits'(-ix) : MagBits'(ix);
    assign iay = iy[SampleBits-1] ? MagBits'(-iy) : MagBits'(iy);
    assign isq = SqBits'(iax * iax) + SqBits'(iay * iay);

    always_comb begin
        in_rec.neg_x = ix[SampleBits-1];
        in_rec.neg_y = iy[SampleBits-1];
        in_rec.ax    = iax;
        in_rec.ay    = iay;
        in_rec.dz    = dz_reg;
        in_rec.dead  = isq < SqBits'(dz_reg * dz_reg);
        in_rec.rem   = isq;
        in_rec.root  = '0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_chain[0] <= in_rec;
        end
    end

    // Square root cells, most significant result bit first.
    genvar g;
    generate
        for (g = 0; g < SqrtCells; g++) begin : g_sqrt
            srdz_sqrt_cell u_cell (
                .aclk    (aclk),
                .en      (adv),
                .bit_pos (5'(SqrtCells - 1 - g)),
                .in_rec  (sq_chain[g]),
                .out_rec (sq_chain[g+1])
            );
        end
    endgenerate

    // Setup cell: divisors and dividends for direction and factor.
    srdz_sq_t            sr;
    logic [RootBits-1:0] m, dn;
    srdz_dv_t            dv_in;
    srdz_dv_t            dv_chain [DivCells+1];

    assign sr = sq_chain[SqrtCells];
    assign m  = sr.root;
    assign dn = RootBits'(OneQ) - RootBits'(sr.dz);

    always_comb begin
        dv_in       = '0;
        dv_in.neg_x = sr.neg_x;
        dv_in.neg_y = sr.neg_y;
        dv_in.dead  = sr.dead;
        dv_in.zero  = (m == '0);
        dv_in.den_m = (m == '0) ? RootBits'(1) : m;
        dv_in.den_k = dn;
        // Rounding: (n + den/2) / den; the sum fits in the numerator width.
        dv_in.dx.num = NumBits'({sr.ax, FracBits'(0)} + NumBits'(m >> 1));
        dv_in.dy.num = NumBits'({sr.ay, FracBits'(0)} + NumBits'(m >> 1));
        dv_in.dk.num = NumBits'({MagBits'(m - RootBits'(sr.dz)), FracBits'(0)}
                       + NumBits'(dn >> 1));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_chain[0] <= dv_in;
        end
    end

    generate
        for (g = 0; g < DivCells; g++) begin : g_div
            srdz_div_cell u_cell (
                .aclk    (aclk),
                .en      (adv),
                .in_rec  (g == 0 ? dv_chain[0] : dv_chain[g]),
                .out_rec (dv_chain[g+1])
            );
        end
    endgenerate

    // Multiply cell: clamp directions, scale by the factor.
    srdz_dv_t             dr;
    logic [MagBits-1:0]   dxm, dym;
    logic [QuoBits-1:0]   qk;
    logic [ProdBits-1:0]  px_n, py_n;
    logic [ProdBits-1:0]  px_reg, py_reg;
    logic [MagBits-1:0]   dxm_reg, dym_reg;
    logic                 nx_reg, ny_reg, dead_reg, zero_reg;

    assign dr = dv_chain[DivCells];

    function automatic logic [MagBits-1:0] clamp(logic [QuoBits-1:0] q, logic neg);
        logic [QuoBits-1:0] lim;
        lim = neg ? QuoBits'(OneQ) : QuoBits'(OneQ - 1'b1);
        return (q > lim) ? MagBits'(lim) : MagBits'(q);
    endfunction

    // With a radius close to one the factor grows far above one, so the
    // full quotient is used and the product is saturated afterwards.
    assign dxm  = clamp(dr.dx.quo, dr.neg_x);
    assign dym  = clamp(dr.dy.quo, dr.neg_y);
    assign qk   = dr.dk.quo;
    assign px_n = ProdBits'(dxm * qk) + ProdBits'(OneQ >> 1);
    assign py_n = ProdBits'(dym * qk) + ProdBits'(OneQ >> 1);

    always_ff @(posedge aclk) begin
        if (adv) begin
            px_reg   <= px_n;
            py_reg   <= py_n;
            dxm_reg  <= dxm;
            dym_reg  <= dym;
            nx_reg   <= dr.neg_x;
            ny_reg   <= dr.neg_y;
            dead_reg <= dr.dead;
            zero_reg <= dr.zero || dr.dead;
        end
    end

    // Output cell: sign, saturate, register.
    function automatic sample_t pack(logic neg, logic [ProdBits-1:0] mag);
        logic [ProdBits-1:0] c;
        if (neg) begin
            c = (mag > ProdBits'(OneQ)) ? ProdBits'(OneQ) : mag;
            return SampleBits'(-c);
        end
        c = (mag > ProdBits'(OneQ - 1'b1)) ? ProdBits'(OneQ - 1'b1) : mag;
        return SampleBits'(c);
    endfunction

    logic [ProdBits-1:0] sx, sy;
    assign sx = px_reg >> FracBits;
    assign sy = py_reg >> FracBits;

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (zero_reg) begin
                m_tdata <= '0;
            end else begin
                m_tdata <= {pack(ny_reg, ProdBits'(dym_reg)),
                            pack(nx_reg, ProdBits'(dxm_reg)),
                            pack(ny_reg, sy), pack(nx_reg, sx)};
            end
            m_tuser <= dead_reg;
        end
    end
endmodule

>>> bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for scaled_radial_dead_zone.
// Drives stick samples through the stream input with random gaps, predicts
// each result in integer arithmetic or takes a typed-in one, checks it field by
// field at the output, which is stalled at random. The radius is changed between phases.
// ---------------------------------------------------------------------------
module testbench;
    import srdz_pkg::*;

    localparam int Frac       = FracBits;
    localparam longint OneVal = longint'(1) << Frac;
    localparam int Latency    = 60;

    // One predicted result transaction.
    typedef struct packed {
        logic [15:0] scaled_x;
        logic [15:0] scaled_y;
        logic [15:0] dir_x;
        logic [15:0] dir_y;
        logic        dead;
    } stick_out_t;

    // One row of the directed table; has_exp marks a typed-in expectation.
    typedef struct {
        logic [14:0] radius;
        logic        set_radius;
        logic [15:0] ax;
        logic [15:0] ay;
        logic        has_exp;
        stick_out_t  exp;
    } stick_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [14:0] cfg_data;

    // Radius as the predictor sees it; follows every accepted config write.
    logic [14:0] radius_now;
    stick_out_t  pending_results[$];
    int          error_count;
    int          result_count;
    int          dead_count;
    bit          sending_done;

    scaled_radial_dead_zone i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [15:0] axis_x, [31:16] axis_y
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // scaled_x, scaled_y, dir_x, dir_y
        .m_tuser  (m_tuser),    // in_dead_zone
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard limit, far above the slowest correct run (about 1100 items, each with a
    // random idle gap at the input and a random stall at the output, plus the pipeline depth).
    initial begin
        #3000000;
        $display("status: fail");
        $finish;
    end

    function automatic longint div_nearest(longint num, longint den);
        return (num + den / 2) / den;
    endfunction

    function automatic longint floor_root(longint v);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // Sign and clamp a magnitude to the signed sample range.
    function automatic logic [15:0] clamp_signed(bit neg, longint mag);
        if (neg) begin
            if (mag > OneVal) mag = OneVal;
            return 16'(-mag);
        end
        if (mag > OneVal - 1) mag = OneVal - 1;
        return 16'(mag);
    endfunction

    // Expected output of the dead zone for one sample at a given radius.
    function automatic stick_out_t dead_zone_predict(logic [15:0] xin, logic [15:0] yin,
                                                     logic [14:0] radius);
        stick_out_t res;
        longint x, y, ax, ay, d, sq, m, k, dxm, dym, lim_x, lim_y, sx, sy;
        bit nx, ny;
        x  = longint'($signed(xin));
        y  = longint'($signed(yin));
        nx = x < 0;
        ny = y < 0;
        ax = nx ? -x : x;
        ay = ny ? -y : y;
        d  = longint'(radius);
        if (d > OneVal - 1) d = OneVal - 1;
        res = '0;
        sq = ax * ax + ay * ay;
        if (sq < d * d) begin
            res.dead = 1'b1;
            return res;
        end
        m = floor_root(sq);
        if (m == 0) return res;
        lim_x = nx ? OneVal : OneVal - 1;
        lim_y = ny ? OneVal : OneVal - 1;
        dxm = div_nearest(ax << Frac, m);
        dym = div_nearest(ay << Frac, m);
        if (dxm > lim_x) dxm = lim_x;
        if (dym > lim_y) dym = lim_y;
        k  = div_nearest((m - d) << Frac, OneVal - d);
        // Products stay far inside 64 bits at this width.
        sx = (dxm * k + (OneVal >>> 1)) >>> Frac;
        sy = (dym * k + (OneVal >>> 1)) >>> Frac;
        res.scaled_x = clamp_signed(nx, sx);
        res.scaled_y = clamp_signed(ny, sy);
        res.dir_x    = clamp_signed(nx, dxm);
        res.dir_y    = clamp_signed(ny, dym);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch at result %0d: %s got %h expected %h", result_count, what, got,
                 want);
        error_count++;
    endtask

    task automatic write_radius(logic [14:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        radius_now = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every expected transaction has arrived, then drains.
    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (Latency) @(posedge aclk);
    endtask

    // Sends one sample after a random gap; the predictor runs at acceptance.
    task automatic send_sample(logic [15:0] xin, logic [15:0] yin, bit has_exp,
                               stick_out_t typed);
        int gap;
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {yin, xin};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(has_exp ? typed :
                                  dead_zone_predict(xin, yin, radius_now));
    endtask

    // Output side: random stalls, each accepted transaction checked in order.
    initial begin
        stick_out_t want;
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (pending_results.size() == 0) begin
                $display("unexpected result transaction %h/%b", m_tdata, m_tuser);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.scaled_x)
                    report_mismatch("scaled_x", m_tdata[15:0], want.scaled_x);
                if (m_tdata[31:16] !== want.scaled_y)
                    report_mismatch("scaled_y", m_tdata[31:16], want.scaled_y);
                if (m_tdata[47:32] !== want.dir_x)
                    report_mismatch("dir_x", m_tdata[47:32], want.dir_x);
                if (m_tdata[63:48] !== want.dir_y)
                    report_mismatch("dir_y", m_tdata[63:48], want.dir_y);
                if (m_tuser !== want.dead)
                    report_mismatch("in_dead_zone", 16'(m_tuser), 16'(want.dead));
                if (want.dead) dead_count++;
            end
            result_count++;
        end
    end

    stick_row_t directed_rows[$];

    task automatic add_row(logic [14:0] radius, bit set_radius, logic [15:0] xin,
                           logic [15:0] yin, bit has_exp, stick_out_t typed);
        stick_row_t row;
        row.radius     = radius;
        row.set_radius = set_radius;
        row.ax         = xin;
        row.ay         = yin;
        row.has_exp    = has_exp;
        row.exp        = typed;
        directed_rows.push_back(row);
    endtask

    initial begin
        stick_out_t none;
        stick_out_t dead_out;
        logic [14:0] radii[6];
        logic [15:0] xin, yin;
        int phase;
        int mode;
        int ang;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        radius_now   = 15'd8192;
        error_count  = 0;
        result_count = 0;
        dead_count   = 0;
        sending_done = 1'b0;
        none         = '0;
        dead_out     = '0;
        dead_out.dead = 1'b1;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table. The first rows rely on the reset radius of 0.25.
        add_row(15'd0, 0, 16'h0000, 16'h0000, 1, dead_out);
        add_row(15'd0, 0, 16'h1000, 16'h1000, 1, dead_out);
        add_row(15'd0, 0, 16'h2000, 16'h0000, 0, none);
        add_row(15'd0, 0, 16'h7fff, 16'h0000, 0, none);
        add_row(15'd0, 0, 16'h8000, 16'h0000, 0, none);
        add_row(15'd0, 0, 16'h7fff, 16'h7fff, 0, none);
        add_row(15'd0, 0, 16'h8000, 16'h8000, 0, none);
        add_row(15'd0, 0, 16'h8000, 16'h7fff, 0, none);
        add_row(15'd0, 0, 16'h0000, 16'h8000, 0, none);
        add_row(15'd0, 0, 16'hffff, 16'h0001, 1, dead_out);
        // Zero radius: the zero vector is not in the dead zone, all outputs zero.
        add_row(15'd0, 1, 16'h0000, 16'h0000, 1, none);
        add_row(15'd0, 0, 16'h0001, 16'h0000, 0, none);
        add_row(15'd0, 0, 16'hffff, 16'hffff, 0, none);
        add_row(15'd0, 0, 16'h8000, 16'h8000, 0, none);
        add_row(15'd0, 0, 16'h4000, 16'hc000, 0, none);
        // Largest radius: only points of full-scale magnitude or above, such as the far corners, leave the dead zone.
        add_row(15'h7fff, 1, 16'h7ffe, 16'h0000, 1, dead_out);
        add_row(15'h7fff, 0, 16'h7fff, 16'h0000, 0, none);
        add_row(15'h7fff, 0, 16'h8000, 16'h0000, 0, none);
        add_row(15'h7fff, 0, 16'h7fff, 16'h7fff, 0, none);
        add_row(15'h7fff, 0, 16'h8000, 16'h8000, 0, none);
        add_row(15'h7fff, 0, 16'h5a82, 16'h5a82, 0, none);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].set_radius) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                wait_idle();
                write_radius(directed_rows[i].radius);
            end
            send_sample(directed_rows[i].ax, directed_rows[i].ay,
                        directed_rows[i].has_exp, directed_rows[i].exp);
        end

        // Random phases: each one sets a radius, extremes included.
        radii = '{15'd0, 15'd8192, 15'h7fff, 15'd1, 15'h4000, 15'd0};
        for (phase = 0; phase < 6; phase++) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            // The sender holds off until every expected result has come.
            wait_idle();
            write_radius(phase == 5 ? 15'($urandom) : radii[phase]);
            repeat (172) begin
                mode = $urandom_range(0, 9);
                xin  = 16'($urandom);
                yin  = 16'($urandom);
                if (mode < 2) begin
                    // Small deflections around the radius edge.
                    xin = 16'($signed(16'($urandom_range(0, 2 * 16'(radius_now) + 2))) >>> 1);
                    yin = 16'($signed(16'($urandom_range(0, 16'(radius_now) + 1))));
                    if ($urandom_range(0, 1)) xin = -xin;
                    if ($urandom_range(0, 1)) yin = -yin;
                end else if (mode < 4) begin
                    // Points on or near an axis or the diagonal.
                    ang = $urandom_range(0, 3);
                    if (ang == 0) yin = 16'($urandom_range(0, 2)) - 16'd1;
                    else if (ang == 1) xin = 16'($urandom_range(0, 2)) - 16'd1;
                    else if (ang == 2) yin = xin;
                    else yin = -xin;
                end else if (mode == 4) begin
                    xin = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                end
                send_sample(xin, yin, 0, none);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_idle();

        $display("covered %0d results (%0d in the dead zone) over several radius settings",
                 result_count, dead_count);
        $display("radius extremes 0 and 0x7fff, full-scale corners and near-axis samples");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", error_count,
                     pending_results.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
